### hw/rtl/fsp_pkg.sv
// fsp_pkg: shared types and constants for the format specifier parser
// parse phases, status and size codes, result record, conversion rule check
// no dependencies
package fsp_pkg;

    localparam int NumWidth = 63;

    typedef enum logic [3:0] {
        PH_TEXT    = 4'd0,
        PH_DISCARD = 4'd1,
        PH_FLAGS   = 4'd2,
        PH_WDIG    = 4'd3,
        PH_WSTAR   = 4'd4,
        PH_DOT     = 4'd5,
        PH_PDIG    = 4'd6,
        PH_PSTAR   = 4'd7,
        PH_LH      = 4'd8,
        PH_LL      = 4'd9,
        PH_LW      = 4'd10,
        PH_LWDIG   = 4'd11,
        PH_CONV    = 4'd12
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_END      = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LIT  = 2'd1;
    localparam logic [1:0] KIND_ARG  = 2'd2;

    localparam logic [3:0] SZ_NONE = 4'd0;
    localparam logic [3:0] SZ_HH   = 4'd1;
    localparam logic [3:0] SZ_H    = 4'd2;
    localparam logic [3:0] SZ_L    = 4'd3;
    localparam logic [3:0] SZ_LL   = 4'd4;
    localparam logic [3:0] SZ_BIGL = 4'd5;
    localparam logic [3:0] SZ_W8   = 4'd6;
    localparam logic [3:0] SZ_W16  = 4'd7;
    localparam logic [3:0] SZ_W32  = 4'd8;
    localparam logic [3:0] SZ_W64  = 4'd9;

    localparam logic [4:0] FL_MINUS = 5'b00001;
    localparam logic [4:0] FL_PLUS  = 5'b00010;
    localparam logic [4:0] FL_SPACE = 5'b00100;
    localparam logic [4:0] FL_HASH  = 5'b01000;
    localparam logic [4:0] FL_ZERO  = 5'b10000;

    typedef struct packed {
        logic [1:0]          status;
        logic [4:0]          flag_set;
        logic [1:0]          width_mode;
        logic [NumWidth-1:0] width_amount;
        logic [1:0]          precision_mode;
        logic [NumWidth-1:0] precision_amount;
        logic [3:0]          size_code;
        logic [7:0]          conversion_char;
        logic                string_done;
    } result_t;

    function automatic logic size_is_int(input logic [3:0] s);
        return (s != SZ_L) && (s != SZ_BIGL);
    endfunction

    // size and flag rules per conversion byte
    function automatic logic conv_ok(input logic [7:0] c, input logic [3:0] s,
                                     input logic [4:0] fl, input logic hasw,
                                     input logic hasp);
        logic minus_only;
        minus_only = (fl & ~FL_MINUS) == 5'd0;
        case (c)
            "d", "i", "u", "o", "x", "X", "b", "B":
                return size_is_int(s);
            "f", "F", "e", "E", "g", "G", "a", "A":
                return (s == SZ_NONE) || (s == SZ_BIGL);
            "c":
                return ((s == SZ_NONE) || (s == SZ_L)) && !hasp && minus_only;
            "s":
                return ((s == SZ_NONE) || (s == SZ_L)) && minus_only;
            "p":
                return (s == SZ_NONE) && !hasp && minus_only;
            "n":
                return size_is_int(s) && (fl == 5'd0) && !hasw && !hasp;
            "%":
                return (s == SZ_NONE) && (fl == 5'd0) && !hasw && !hasp;
            default:
                return 1'b0;
        endcase
    endfunction

endpackage

### hw/rtl/fsp_in_stage.sv
// fsp_in_stage: input register for the format byte stream
// holds one byte until the parser takes it; uses fsp_pkg-free plain logic
module fsp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       format_valid,
    output logic       format_ready,
    input  logic [7:0] format_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign format_ready = !valid_reg || take;
    assign valid_next   = (format_valid && format_ready) ? 1'b1
                        : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (format_valid && format_ready)
            byte_reg <= format_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

### hw/rtl/fsp_parser.sv
// fsp_parser: specifier state machine, one byte per step
// holds the parse context and forms at most one result per byte; uses fsp_pkg
module fsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output logic                res_valid,
    output fsp_pkg::result_t    res
);

    localparam int NW = fsp_pkg::NumWidth;

    fsp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]    flags_reg, flags_next;
    logic [1:0]    wkind_reg, wkind_next;
    logic [NW-1:0] wheld_reg, wheld_next;
    logic [1:0]    pkind_reg, pkind_next;
    logic [NW-1:0] pheld_reg, pheld_next;
    logic [3:0]    size_reg, size_next;
    logic [NW-1:0] acc_reg, acc_next;
    logic          ovf_reg, ovf_next;
    logic          lead_reg, lead_next;

    logic          dig;
    logic [NW+3:0] acc_sum;
    logic          acc_ok;
    logic [NW-1:0] acc_new;
    logic [NW-1:0] dig_val;

    logic          do_prec, do_size, do_conv, emit;
    logic [1:0]    emit_code;

    assign dig     = (byte_in >= "0") && (byte_in <= "9");
    assign dig_val = {{(NW-4){1'b0}}, byte_in[3:0]};
    // times ten as two shifts, plus the digit
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {4'b0000, dig_val};
    assign acc_ok  = acc_sum[NW+3:NW] == 4'd0;
    assign acc_new = acc_sum[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fsp_pkg::PH_TEXT;
            flags_reg <= '0;
            wkind_reg <= '0;
            wheld_reg <= '0;
            pkind_reg <= '0;
            pheld_reg <= '0;
            size_reg  <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            lead_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            wkind_reg <= wkind_next;
            wheld_reg <= wheld_next;
            pkind_reg <= pkind_next;
            pheld_reg <= pheld_next;
            size_reg  <= size_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            lead_reg  <= lead_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        wkind_next = wkind_reg;
        wheld_next = wheld_reg;
        pkind_next = pkind_reg;
        pheld_next = pheld_reg;
        size_next  = size_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        lead_next  = dig ? lead_reg : 1'b0;
        do_prec    = 1'b0;
        do_size    = 1'b0;
        do_conv    = 1'b0;
        emit       = 1'b0;
        emit_code  = fsp_pkg::ST_OK;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            fsp_pkg::PH_TEXT:
            begin
                if (byte_in == 8'd0)
                begin
                    emit      = 1'b1;
                    emit_code = fsp_pkg::ST_END;
                end
                else if (byte_in == "%")
                begin
                    flags_next = '0;
                    wkind_next = fsp_pkg::KIND_NONE;
                    wheld_next = '0;
                    pkind_next = fsp_pkg::KIND_NONE;
                    pheld_next = '0;
                    size_next  = fsp_pkg::SZ_NONE;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    lead_next  = 1'b1;
                    phase_next = fsp_pkg::PH_FLAGS;
                end
            end
            fsp_pkg::PH_DISCARD:
            begin
                if (byte_in == 8'd0)
                    phase_next = fsp_pkg::PH_TEXT;
            end
            fsp_pkg::PH_FLAGS:
            begin
                case (byte_in)
                    "-": flags_next = flags_reg | fsp_pkg::FL_MINUS;
                    "+": flags_next = flags_reg | fsp_pkg::FL_PLUS;
                    " ": flags_next = flags_reg | fsp_pkg::FL_SPACE;
                    "#": flags_next = flags_reg | fsp_pkg::FL_HASH;
                    "0": flags_next = flags_reg | fsp_pkg::FL_ZERO;
                    "*":
                    begin
                        wkind_next = fsp_pkg::KIND_ARG;
                        phase_next = fsp_pkg::PH_WSTAR;
                    end
                    default:
                    begin
                        if (dig)
                        begin
                            wkind_next = fsp_pkg::KIND_LIT;
                            acc_next   = dig_val;
                            ovf_next   = 1'b0;
                            phase_next = fsp_pkg::PH_WDIG;
                        end
                        else
                            do_prec = 1'b1;
                    end
                endcase
            end
            fsp_pkg::PH_WDIG, fsp_pkg::PH_PDIG:
            begin
                if (ovf_reg)
                begin
                    if (!dig)
                    begin
                        emit      = 1'b1;
                        emit_code = (byte_in == "$") ? fsp_pkg::ST_INVALID
                                                     : fsp_pkg::ST_OVERFLOW;
                    end
                end
                else if (dig)
                begin
                    if (acc_ok)
                        acc_next = acc_new;
                    else if (lead_reg || phase_reg == fsp_pkg::PH_PDIG)
                        ovf_next = 1'b1;
                    else
                    begin
                        emit      = 1'b1;
                        emit_code = fsp_pkg::ST_OVERFLOW;
                    end
                end
                else if (phase_reg == fsp_pkg::PH_WDIG)
                begin
                    wheld_next = acc_reg;
                    do_prec    = 1'b1;
                end
                else if (byte_in == "$")
                begin
                    emit      = 1'b1;
                    emit_code = fsp_pkg::ST_INVALID;
                end
                else
                begin
                    pheld_next = acc_reg;
                    do_size    = 1'b1;
                end
            end
            fsp_pkg::PH_WSTAR, fsp_pkg::PH_PSTAR:
            begin
                if (dig)
                begin
                    emit      = 1'b1;
                    emit_code = fsp_pkg::ST_INVALID;
                end
                else if (phase_reg == fsp_pkg::PH_WSTAR)
                    do_prec = 1'b1;
                else
                    do_size = 1'b1;
            end
            fsp_pkg::PH_DOT:
            begin
                if (byte_in == "*")
                begin
                    pkind_next = fsp_pkg::KIND_ARG;
                    phase_next = fsp_pkg::PH_PSTAR;
                end
                else
                begin
                    pkind_next = fsp_pkg::KIND_LIT;
                    if (dig)
                    begin
                        acc_next   = dig_val;
                        ovf_next   = 1'b0;
                        phase_next = fsp_pkg::PH_PDIG;
                    end
                    else
                        do_size = 1'b1;
                end
            end
            fsp_pkg::PH_LH:
            begin
                if (byte_in == "h")
                begin
                    size_next  = fsp_pkg::SZ_HH;
                    phase_next = fsp_pkg::PH_CONV;
                end
                else
                    do_conv = 1'b1;
            end
            fsp_pkg::PH_LL:
            begin
                if (byte_in == "l")
                begin
                    size_next  = fsp_pkg::SZ_LL;
                    phase_next = fsp_pkg::PH_CONV;
                end
                else
                    do_conv = 1'b1;
            end
            fsp_pkg::PH_LW:
            begin
                if (!dig)
                begin
                    emit      = 1'b1;
                    emit_code = fsp_pkg::ST_INVALID;
                end
                else
                begin
                    acc_next   = dig_val;
                    ovf_next   = 1'b0;
                    phase_next = fsp_pkg::PH_LWDIG;
                end
            end
            fsp_pkg::PH_LWDIG:
            begin
                if (dig)
                begin
                    if (acc_ok)
                        acc_next = acc_new;
                    else
                    begin
                        emit      = 1'b1;
                        emit_code = fsp_pkg::ST_OVERFLOW;
                    end
                end
                else
                begin
                    do_conv = 1'b1;
                    if (acc_reg == NW'(8))
                        size_next = fsp_pkg::SZ_W8;
                    else if (acc_reg == NW'(16))
                        size_next = fsp_pkg::SZ_W16;
                    else if (acc_reg == NW'(32))
                        size_next = fsp_pkg::SZ_W32;
                    else if (acc_reg == NW'(64))
                        size_next = fsp_pkg::SZ_W64;
                    else
                    begin
                        do_conv   = 1'b0;
                        emit      = 1'b1;
                        emit_code = fsp_pkg::ST_INVALID;
                    end
                end
            end
            fsp_pkg::PH_CONV:
                do_conv = 1'b1;
            default:
                phase_next = fsp_pkg::PH_TEXT;
        endcase

        // fall-through chain: precision, then size, then conversion
        if (do_prec)
        begin
            if (byte_in == ".")
                phase_next = fsp_pkg::PH_DOT;
            else
                do_size = 1'b1;
        end

        if (do_size)
        begin
            case (byte_in)
                "h":
                begin
                    size_next  = fsp_pkg::SZ_H;
                    phase_next = fsp_pkg::PH_LH;
                end
                "l":
                begin
                    size_next  = fsp_pkg::SZ_L;
                    phase_next = fsp_pkg::PH_LL;
                end
                "L":
                begin
                    size_next  = fsp_pkg::SZ_BIGL;
                    phase_next = fsp_pkg::PH_CONV;
                end
                "w":
                    phase_next = fsp_pkg::PH_LW;
                "j", "z", "t":
                begin
                    emit      = 1'b1;
                    emit_code = fsp_pkg::ST_INVALID;
                end
                default:
                    do_conv = 1'b1;
            endcase
        end

        if (do_conv)
        begin
            if (byte_in == 8'd0
                || !fsp_pkg::conv_ok(byte_in, size_next, flags_next,
                                     wkind_next != fsp_pkg::KIND_NONE,
                                     pkind_next != fsp_pkg::KIND_NONE))
            begin
                emit      = 1'b1;
                emit_code = fsp_pkg::ST_INVALID;
            end
            else
            begin
                res_valid            = 1'b1;
                res.status           = fsp_pkg::ST_OK;
                res.flag_set         = flags_next;
                res.width_mode       = wkind_next;
                res.width_amount     = wheld_next;
                res.precision_mode   = pkind_next;
                res.precision_amount = pheld_next;
                res.size_code        = size_next;
                res.conversion_char  = byte_in;
                res.string_done      = 1'b0;
                phase_next           = fsp_pkg::PH_TEXT;
            end
        end

        if (emit)
        begin
            res_valid       = 1'b1;
            res             = '0;
            res.status      = emit_code;
            res.string_done = 1'b1;
            phase_next      = (byte_in == 8'd0 || emit_code == fsp_pkg::ST_END)
                            ? fsp_pkg::PH_TEXT : fsp_pkg::PH_DISCARD;
            ovf_next        = 1'b0;
            lead_next       = 1'b0;
        end
    end

endmodule

### hw/rtl/format_specifier_parser.sv
// format_specifier_parser: top level of the printf-style specifier parser
// input register, parser state machine and result register; uses fsp_pkg,
// fsp_in_stage and fsp_parser
//
// Feed the format string one byte per transaction, a zero byte ending each
// string. The block takes one byte every cycle unless the format side stalls:
// a byte is held in the input register, is parsed against the held specifier
// context in a single pass, and any result is written to the result register
// as the byte leaves the input register. Each byte yields no result or one: a
// parsed specifier, an error, or a clean end of string. After an error, bytes
// are dropped up to and including the next zero. The format side stalls only
// while a result waits and the input register is also full.
module format_specifier_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        format_valid,
    output logic        format_ready,
    input  logic [7:0]  format_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [4:0]  flag_set,
    output logic [1:0]  width_mode,
    output logic [62:0] width_amount,
    output logic [1:0]  precision_mode,
    output logic [62:0] precision_amount,
    output logic [3:0]  size_code,
    output logic [7:0]  conversion_char,
    output logic        string_done
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             advance;
    logic             step_valid;
    fsp_pkg::result_t step_res;

    logic             out_valid_reg, out_valid_next;
    fsp_pkg::result_t out_reg;

    // a byte moves on when the result slot is free or being emptied
    assign advance = held_valid && (!out_valid_reg || result_ready);

    fsp_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .format_valid (format_valid),
        .format_ready (format_ready),
        .format_byte  (format_byte),
        .take         (advance),
        .held_valid   (held_valid),
        .held_byte    (held_byte)
    );

    fsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (held_byte),
        .res_valid (step_valid),
        .res       (step_res)
    );

    assign out_valid_next = advance ? step_valid
                          : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
            out_reg <= step_res;
    end

    assign result_valid     = out_valid_reg;
    assign status           = out_reg.status;
    assign flag_set         = out_reg.flag_set;
    assign width_mode       = out_reg.width_mode;
    assign width_amount     = out_reg.width_amount;
    assign precision_mode   = out_reg.precision_mode;
    assign precision_amount = out_reg.precision_amount;
    assign size_code        = out_reg.size_code;
    assign conversion_char  = out_reg.conversion_char;
    assign string_done      = out_reg.string_done;

endmodule
